>>> hdl/hsfc_pkg.sv
`timescale 1ns / 1ps

package hsfc_pkg;

   localparam logic [7:0]  SGL_BIAS_ADJ   = 8'd112;
   localparam logic [7:0]  SGL_SUB_BASE   = 8'd103;
   localparam logic [7:0]  SGL_INF_EXP    = 8'hFF;
   localparam logic [4:0]  HALF_INF_EXP   = 5'h1F;
   localparam logic [4:0]  HALF_EXP_MAX   = 5'h1F;
   localparam logic [7:0]  HALF_OVF_EXP   = 8'd142;
   localparam logic [7:0]  HALF_MIN_EXP   = 8'd112;
   localparam logic [7:0]  SUB_SHIFT_BASE = 8'd125;
   localparam logic [7:0]  SHIFT_CAP      = 8'd31;
   localparam logic [30:0] RND_HALF_ULP   = 31'h0000_1000;
   localparam logic [30:0] SGL_INF_MAG    = 31'h7F80_0000;
   localparam logic [23:0] SUB_MANT_ADD   = 24'h7F_F000;
   localparam logic [9:0]  QNAN_BIT       = 10'h200;
   localparam logic [3:0]  HALF_MANT_W    = 4'd10;

   typedef enum logic [1:0] {
      HCLS_ZERO,
      HCLS_SUB,
      HCLS_NORM,
      HCLS_MAX
   } hcls_type;

   typedef enum logic [2:0] {
      CLS_ZERO,
      CLS_NORM,
      CLS_SUB,
      CLS_INF,
      CLS_NAN
   } cls_type;

   typedef struct packed {
      logic        dir;
      logic        sign;
      logic        nan;
      hcls_type    hcls;
      logic [3:0]  lead;
      logic [7:0]  expo;
      logic [22:0] mant;
   } s1_type;

   typedef struct packed {
      logic        dir;
      logic        sign;
      cls_type     cls;
      logic [7:0]  expo;
      logic [23:0] mant;
      logic [4:0]  amt;
   } s2_type;

endpackage

>>> hdl/hsfc_front.sv
`timescale 1ns / 1ps

module hsfc_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic                in_dir,
   input  logic [31:0]         in_value,
   output logic                out_valid,
   input  logic                out_ready,
   output hsfc_pkg::s1_type    out_data
);

   logic             valid_ff;
   hsfc_pkg::s1_type data_ff;
   hsfc_pkg::s1_type data_in;
   logic [30:0]      rnd;
   logic [4:0]       hexp;
   logic [9:0]       hmant;
   logic [3:0]       lead;

   always_comb begin
      rnd   = in_value[30:0] + hsfc_pkg::RND_HALF_ULP;
      hexp  = in_value[14:10];
      hmant = in_value[9:0];
      lead  = 4'd0;
      for (int i = 0; i < 10; i++) begin
         if (hmant[i]) begin
            lead = 4'(i);
         end
      end

      data_in.dir  = in_dir;
      data_in.lead = lead;
      if (!in_dir) begin
         data_in.sign = in_value[15];
         data_in.nan  = 1'b0;
         data_in.expo = {3'b000, hexp};
         data_in.mant = {13'd0, hmant};
         if (hexp == hsfc_pkg::HALF_EXP_MAX) begin
            data_in.hcls = hsfc_pkg::HCLS_MAX;
         end else if (hexp != 5'd0) begin
            data_in.hcls = hsfc_pkg::HCLS_NORM;
         end else if (hmant != 10'd0) begin
            data_in.hcls = hsfc_pkg::HCLS_SUB;
         end else begin
            data_in.hcls = hsfc_pkg::HCLS_ZERO;
         end
      end else begin
         data_in.sign = in_value[31];
         data_in.nan  = (in_value[30:0] > hsfc_pkg::SGL_INF_MAG);
         data_in.hcls = hsfc_pkg::HCLS_ZERO;
         data_in.expo = rnd[30:23];
         data_in.mant = data_in.nan ? in_value[22:0] : rnd[22:0];
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

>>> hdl/hsfc_classify.sv
`timescale 1ns / 1ps

module hsfc_classify (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  hsfc_pkg::s1_type    in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output hsfc_pkg::s2_type    out_data
);

   logic             valid_ff;
   hsfc_pkg::s2_type data_ff;
   hsfc_pkg::s2_type data_in;
   logic [3:0]       lshift;
   logic [9:0]       hnorm;
   logic [7:0]       nexp;
   logic [7:0]       diff;

   always_comb begin
      lshift = hsfc_pkg::HALF_MANT_W - in_data.lead;
      hnorm  = in_data.mant[9:0] << lshift;
      nexp   = in_data.expo - hsfc_pkg::HALF_MIN_EXP;
      diff   = hsfc_pkg::SUB_SHIFT_BASE - in_data.expo;

      data_in.dir  = in_data.dir;
      data_in.sign = in_data.sign;
      data_in.amt  = 5'd0;
      data_in.expo = 8'd0;
      data_in.mant = 24'd0;
      data_in.cls  = hsfc_pkg::CLS_ZERO;
      if (!in_data.dir) begin
         case (in_data.hcls)
            hsfc_pkg::HCLS_MAX: begin
               if (in_data.mant[9:0] != 10'd0) begin
                  data_in.cls  = hsfc_pkg::CLS_NAN;
                  data_in.mant = {14'd0, in_data.mant[9:0] | hsfc_pkg::QNAN_BIT};
               end else begin
                  data_in.cls  = hsfc_pkg::CLS_INF;
               end
            end
            hsfc_pkg::HCLS_NORM: begin
               data_in.cls  = hsfc_pkg::CLS_NORM;
               data_in.expo = in_data.expo + hsfc_pkg::SGL_BIAS_ADJ;
               data_in.mant = {14'd0, in_data.mant[9:0]};
            end
            hsfc_pkg::HCLS_SUB: begin
               data_in.cls  = hsfc_pkg::CLS_NORM;
               data_in.expo = hsfc_pkg::SGL_SUB_BASE + {4'd0, in_data.lead};
               data_in.mant = {14'd0, hnorm};
            end
            default: begin
               data_in.cls  = hsfc_pkg::CLS_ZERO;
            end
         endcase
      end else begin
         if (in_data.nan) begin
            data_in.cls  = hsfc_pkg::CLS_NAN;
            data_in.mant = {14'd0, in_data.mant[22:13] | hsfc_pkg::QNAN_BIT};
         end else if (in_data.expo > hsfc_pkg::HALF_OVF_EXP) begin
            data_in.cls  = hsfc_pkg::CLS_INF;
         end else if (in_data.expo > hsfc_pkg::HALF_MIN_EXP) begin
            data_in.cls  = hsfc_pkg::CLS_NORM;
            data_in.expo = {3'b000, nexp[4:0]};
            data_in.mant = {14'd0, in_data.mant[22:13]};
         end else begin
            data_in.cls  = hsfc_pkg::CLS_SUB;
            data_in.mant = {1'b0, in_data.mant} + hsfc_pkg::SUB_MANT_ADD;
            data_in.amt  = (diff > hsfc_pkg::SHIFT_CAP) ? hsfc_pkg::SHIFT_CAP[4:0] : diff[4:0];
         end
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

>>> hdl/hsfc_pack.sv
`timescale 1ns / 1ps

module hsfc_pack (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  hsfc_pkg::s2_type    in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [31:0]         out_value
);

   logic        valid_ff;
   logic [31:0] value_ff;
   logic [31:0] value_in;
   logic [23:0] shifted;
   logic [24:0] rsum;
   logic [23:0] rhalf;

   always_comb begin
      shifted = in_data.mant >> in_data.amt;
      rsum    = {1'b0, shifted} + 25'd1;
      rhalf   = rsum[24:1];
      if (!in_data.dir) begin
         case (in_data.cls)
            hsfc_pkg::CLS_NORM: begin
               value_in = {in_data.sign, in_data.expo, in_data.mant[9:0], 13'd0};
            end
            hsfc_pkg::CLS_INF: begin
               value_in = {in_data.sign, hsfc_pkg::SGL_INF_EXP, 23'd0};
            end
            hsfc_pkg::CLS_NAN: begin
               value_in = {in_data.sign, hsfc_pkg::SGL_INF_EXP, in_data.mant[9:0], 13'd0};
            end
            default: begin
               value_in = {in_data.sign, 31'd0};
            end
         endcase
      end else begin
         case (in_data.cls)
            hsfc_pkg::CLS_NORM: begin
               value_in = {16'd0, in_data.sign, in_data.expo[4:0], in_data.mant[9:0]};
            end
            hsfc_pkg::CLS_INF: begin
               value_in = {16'd0, in_data.sign, hsfc_pkg::HALF_INF_EXP, 10'd0};
            end
            hsfc_pkg::CLS_NAN: begin
               value_in = {16'd0, in_data.sign, hsfc_pkg::HALF_INF_EXP, in_data.mant[9:0]};
            end
            hsfc_pkg::CLS_SUB: begin
               value_in = {16'd0, in_data.sign, rhalf[14:0]};
            end
            default: begin
               value_in = {16'd0, in_data.sign, 15'd0};
            end
         endcase
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_value = value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         value_ff <= value_in;
      end
   end

endmodule

>>> hdl/half_single_float_converter_core.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake               Payload
// req       in         req_tvalid/req_tready   tdata: value_in, tuser: req_type
// rsp       out        rsp_tvalid/rsp_tready   tdata: value_out
//
// Three register stages: round add and leading-one search, classify and
// normalise, final shift/round and pack. One word a clock while rsp is not stalled.
// Synchronous active-high reset empties every stage; payload is not reset.
// A stalled rsp holds each stage in place; a stage refills as soon as it drains.

module half_single_float_converter_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value_in
   input  logic [0:0]  req_tuser,   // [0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [31:0] value_out
);

   logic             st1_valid;
   logic             st1_ready;
   hsfc_pkg::s1_type st1_data;
   logic             st2_valid;
   logic             st2_ready;
   hsfc_pkg::s2_type st2_data;

   hsfc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_dir    (req_tuser[0]),
      .in_value  (req_tdata),
      .out_valid (st1_valid),
      .out_ready (st1_ready),
      .out_data  (st1_data)
   );

   hsfc_classify u_classify (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (st1_valid),
      .in_ready  (st1_ready),
      .in_data   (st1_data),
      .out_valid (st2_valid),
      .out_ready (st2_ready),
      .out_data  (st2_data)
   );

   hsfc_pack u_pack (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (st2_valid),
      .in_ready  (st2_ready),
      .in_data   (st2_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_value (rsp_tdata)
   );

`ifndef ASSERT_OFF
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> st1_valid && st2_valid && rsp_tvalid)
      else $error("input stalled with an empty stage");

   a_sub_dir: assert property (@(posedge clock) disable iff (reset)
      st2_valid && st2_data.cls == hsfc_pkg::CLS_SUB |-> st2_data.dir)
      else $error("subnormal rounding class on half to single word");

   a_h2s_exp: assert property (@(posedge clock) disable iff (reset)
      st2_valid && !st2_data.dir && st2_data.cls == hsfc_pkg::CLS_NORM
      |-> st2_data.expo != 8'd0 && st2_data.expo != hsfc_pkg::SGL_INF_EXP)
      else $error("widened exponent out of normal range");
`endif

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   localparam logic DIR_HALF_TO_SINGLE = 1'b0;
   localparam logic DIR_SINGLE_TO_HALF = 1'b1;
   localparam int   RANDOM_WORDS       = 450;
   localparam int   CALM_WORDS         = 60;
   localparam int   SETTLE_CYCLES      = 20;

   typedef struct {
      logic        dir;
      logic [31:0] bits;
      bit          drain_first;
   } conv_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = 32'h0;   // [31:0] value_in
   logic [0:0]  req_tuser = 1'b0;    // [0] req_type
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;          // [31:0] value_out

   conv_word_type pending_words[$];
   logic [31:0]   expected_results[$];
   int            mismatch_count = 0;
   int            send_gap = 0;
   int            stall_left = 0;
   bit            req_taken = 1'b0;

   half_single_float_converter_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [31:0] widen_half(logic [15:0] h);
      logic [4:0] he;
      logic [9:0] hm;
      int         lead;
      he   = h[14:10];
      hm   = h[9:0];
      lead = 0;
      if (he == 5'h1F) begin
         return {h[15], 8'hFF, (hm != 10'h0) ? (hm | 10'h200) : hm, 13'h0};
      end
      if (he != 5'h0) begin
         return {h[15], 8'(he) + 8'd112, hm, 13'h0};
      end
      if (hm == 10'h0) begin
         return {h[15], 31'h0};
      end
      for (int i = 0; i < 10; i++) begin
         if (hm[i]) lead = i;
      end
      return {h[15], 8'(103 + lead), 10'(hm << (10 - lead)), 13'h0};
   endfunction

   function automatic logic [31:0] narrow_single(logic [31:0] s);
      logic [31:0] rnd;
      logic [7:0]  re;
      logic [31:0] m;
      int          sh;
      rnd = s + 32'h0000_1000;
      re  = rnd[30:23];
      m   = {9'h0, rnd[22:0]};
      if (s[30:0] > 31'h7F80_0000) begin
         return {16'h0, s[31], 5'h1F, s[22:13] | 10'h200};
      end
      if (re > 8'd142) begin
         return {16'h0, s[31], 5'h1F, 10'h0};
      end
      if (re > 8'd112) begin
         return {16'h0, s[31], 5'(re - 8'd112), m[22:13]};
      end
      sh = 125 - int'(re);
      if (sh > 31) sh = 31;
      m = ((m + 32'h007F_F000) >> sh) + 32'h1;
      m = m >> 1;
      return {16'h0, s[31], 15'(m)};
   endfunction

   function automatic logic [31:0] predict_conversion(logic dir, logic [31:0] bits);
      if (dir == DIR_HALF_TO_SINGLE) return widen_half(bits[15:0]);
      return narrow_single(bits);
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t: %s: value_out got %08h want %08h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   task automatic push_word(logic dir, logic [31:0] bits, bit drain_first = 1'b0);
      conv_word_type w;
      w.dir         = dir;
      w.bits        = bits;
      w.drain_first = drain_first;
      pending_words.push_back(w);
   endtask

   function automatic conv_word_type make_random_word();
      conv_word_type w;
      logic [31:0]   v;
      int            pick;
      v    = $urandom;
      pick = $urandom_range(0, 5);
      w.drain_first = 1'b0;
      w.dir = (pick == 0) ? 1'($urandom) : ((pick <= 2) ? DIR_HALF_TO_SINGLE
                                                         : DIR_SINGLE_TO_HALF);
      case (pick)
         1: begin
            case ($urandom_range(0, 2))
               0: v[14:10] = 5'h00;
               1: v[14:10] = 5'h1F;
               default: v[14:10] = 5'($urandom_range(1, 30));
            endcase
            if ($urandom_range(0, 3) == 0) v[9:0] = 10'h0;
         end
         3: v[30:23] = 8'($urandom_range(96, 146));
         4: begin
            v[30:23] = 8'($urandom_range(96, 146));
            case ($urandom_range(0, 2))
               0: v[12:0] = 13'h1000;
               1: v[12:0] = 13'h0FFF;
               default: v[22:0] = 23'h7F_F000 | 23'(v[12:0]);
            endcase
         end
         5: begin
            case ($urandom_range(0, 3))
               0: v[30:23] = 8'h00;
               1: v[30:23] = 8'hFF;
               2: v[30:23] = 8'd112;
               default: v[30:23] = 8'd142;
            endcase
            if ($urandom_range(0, 2) == 0) v[22:0] = 23'h0;
         end
         default: ;
      endcase
      w.bits = v;
      return w;
   endfunction

   // request side: present words, idle in bursts
   always @(negedge clock) begin : drive_req
      conv_word_type w;
      logic          next_valid;
      logic [31:0]   next_data;
      logic [0:0]    next_user;
      next_valid = req_tvalid;
      next_data  = req_tdata;
      next_user  = req_tuser;
      if (!reset && (!req_tvalid || req_taken)) begin
         next_valid = 1'b0;
         if (send_gap > 0) begin
            send_gap--;
         end else if (pending_words.size() > 0 &&
                      (!pending_words[0].drain_first || expected_results.size() == 0)) begin
            w          = pending_words.pop_front();
            next_valid = 1'b1;
            next_data  = w.bits;
            next_user  = w.dir;
            if (pending_words.size() >= CALM_WORDS && $urandom_range(0, 7) == 0)
               send_gap = $urandom_range(1, 14);
         end
      end
      req_taken = 1'b0;
      req_tvalid <= next_valid;
      req_tdata  <= next_data;
      req_tuser  <= next_user;
   end

   // response side: stall in bursts
   always @(negedge clock) begin : drive_rsp
      logic next_ready;
      next_ready = 1'b1;
      if (reset) begin
         next_ready = 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         next_ready = 1'b0;
      end else if (pending_words.size() >= CALM_WORDS && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 13);
         next_ready = 1'b0;
      end
      rsp_tready <= next_ready;
   end

   always @(posedge clock) begin : watch
      logic [31:0] want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_results.push_back(predict_conversion(req_tuser[0], req_tdata));
            req_taken = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected word", rsp_tdata, 32'h0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_tdata !== want) report_mismatch("wrong word", rsp_tdata, want);
            end
         end
      end
   end

   initial begin
      #400000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin : stimulus
      conv_word_type w;
      // half to single: zeros, subnormals, normals, infinities, NaNs, upper bits ignored
      push_word(DIR_HALF_TO_SINGLE, 32'h0000_0000);
      push_word(DIR_HALF_TO_SINGLE, 32'hDEAD_8000);
      push_word(DIR_HALF_TO_SINGLE, 32'h0000_0001);
      push_word(DIR_HALF_TO_SINGLE, 32'hFFFF_83FF);
      push_word(DIR_HALF_TO_SINGLE, 32'h0000_0400);
      push_word(DIR_HALF_TO_SINGLE, 32'h0000_7BFF);
      push_word(DIR_HALF_TO_SINGLE, 32'h0000_FC00);
      push_word(DIR_HALF_TO_SINGLE, 32'h0000_7C01);
      push_word(DIR_HALF_TO_SINGLE, 32'h5555_FFFF);
      // single to half: zeros, subnormals, ties, overflow, infinities, NaNs
      push_word(DIR_SINGLE_TO_HALF, 32'h0000_0000);
      push_word(DIR_SINGLE_TO_HALF, 32'h8000_0001);
      push_word(DIR_SINGLE_TO_HALF, 32'h7F80_0000);
      push_word(DIR_SINGLE_TO_HALF, 32'hFF80_0000);
      push_word(DIR_SINGLE_TO_HALF, 32'h7F80_0001);
      push_word(DIR_SINGLE_TO_HALF, 32'hFFFF_FFFF);
      push_word(DIR_SINGLE_TO_HALF, 32'h477F_E000);
      push_word(DIR_SINGLE_TO_HALF, 32'h477F_F000);
      push_word(DIR_SINGLE_TO_HALF, 32'h3880_0000);
      push_word(DIR_SINGLE_TO_HALF, 32'h3380_0000);
      push_word(DIR_SINGLE_TO_HALF, 32'hB300_0000);
      push_word(DIR_SINGLE_TO_HALF, 32'h387F_FFFF);
      push_word(DIR_SINGLE_TO_HALF, 32'h3F80_1000);
      push_word(DIR_SINGLE_TO_HALF, 32'h2000_0000);
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         w = make_random_word();
         w.drain_first = (i == 0) || (i == RANDOM_WORDS / 2);
         pending_words.push_back(w);
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_words.size() > 0 || req_tvalid || expected_results.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      while (expected_results.size() > 0)
         report_mismatch("missing word", 32'h0, expected_results.pop_front());

      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

>>> sim.f
hdl/hsfc_pkg.sv
hdl/hsfc_front.sv
hdl/hsfc_classify.sv
hdl/hsfc_pack.sv
hdl/half_single_float_converter_core.sv
dv/tb_top.sv
